/* rtl/core/ais_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ais_pkg
// Shared widths, defaults and types for the ascending integer sorter.
// ----------------------------------------------------------------------------
package ais_pkg;

    // word width of one element
    localparam int VALUE_W = 32;

    // default number of entries in the element store
    localparam int DEPTH_DEF = 64;

    typedef logic signed [VALUE_W-1:0] value_t;

endpackage

/* rtl/core/ais_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ais_ram
// Element store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module ais_ram
    import ais_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic          aclk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  value_t        wr_data,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output value_t        rd_data
);

    value_t mem [DEPTH];
    value_t rd_data_reg;

    // write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // read port, registered read data
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* rtl/core/ascending_integer_sorter_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ascending_integer_sorter_top
// Collects a set of signed words into a store, then emits them in ascending
// order once the word marked last has arrived.
// ----------------------------------------------------------------------------
//  Channel  Dir  Handshake          Payload
//  s_       in   s_tvalid/s_tready  s_tdata = value, s_tlast = last_of_set
//  m_       out  m_tvalid/m_tready  m_tdata = sorted_value, m_tlast = is_last,
//                                   m_tuser = overflowed
//
//  Loading takes one word per cycle; words beyond DEPTH are dropped.
//  The run for a set of n words is a selection pass per result, each pass
//  reading the unsorted tail of the set over the single read port of the store.
//  Input is not taken during a run; a stalled m_ holds the next pass in place.
//  Reset (aresetn low, synchronous) clears count, flag and control; the store
//  itself needs no clearing since only entries of the current set are read.
// ----------------------------------------------------------------------------
module ascending_integer_sorter_top
    import ais_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    // s_tdata: [31:0] value
    input  logic [VALUE_W-1:0] s_tdata,
    input  logic               s_tlast,
    input  logic               s_tvalid,
    output logic               s_tready,
    // m_tdata: [31:0] sorted_value
    output logic [VALUE_W-1:0] m_tdata,
    output logic               m_tlast,
    // m_tuser: [0] overflowed
    output logic               m_tuser,
    output logic               m_tvalid,
    input  logic               m_tready
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [CW-1:0] FULL = CW'(DEPTH);

    typedef enum logic [1:0] {
        ST_LOAD,
        ST_SCAN,
        ST_PLACE
    } state_t;

    state_t        state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic          ovf_reg, ovf_next;
    logic [AW-1:0] pos_reg, pos_next;      // position being filled in this pass
    logic [CW-1:0] rd_idx_reg, rd_idx_next;
    logic          rd_valid_reg, rd_valid_next;
    logic [AW-1:0] rd_addr_reg, rd_addr_next;
    value_t        min_reg, min_next;
    logic [AW-1:0] min_idx_reg, min_idx_next;
    value_t        pos_val_reg, pos_val_next;  // old contents of the position

    logic               m_tvalid_reg, m_tvalid_next;
    logic [VALUE_W-1:0] m_tdata_reg, m_tdata_next;
    logic               m_tlast_reg, m_tlast_next;
    logic               m_tuser_reg, m_tuser_next;

    logic          s_fire;
    logic          out_free;
    logic          rd_en;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    value_t        wr_data;
    value_t        rd_data;
    logic          first_rd;
    logic          last_rd;
    logic          take;
    logic          last_pos;

    ais_ram #(
        .DEPTH (DEPTH)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_idx_reg[AW-1:0]),
        .rd_data (rd_data)
    );

    assign s_tready = (state_reg == ST_LOAD);
    assign s_fire   = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;

    // read issue and candidate tracking during a scan
    assign rd_en    = (state_reg == ST_SCAN) && (rd_idx_reg < count_reg);
    assign first_rd = (rd_addr_reg == pos_reg);
    assign last_rd  = rd_valid_reg && (rd_addr_reg == AW'(count_reg - CW'(1)));
    assign take     = first_rd || (rd_data < min_reg);
    assign last_pos = ((CW'(pos_reg) + CW'(1)) == count_reg);

    // store write: loading, or at the end of a pass the old word of the position into the minimum's slot
    always_comb begin
        wr_en   = 1'b0;
        wr_addr = count_reg[AW-1:0];
        wr_data = value_t'(s_tdata);
        if (state_reg == ST_LOAD) begin
            wr_en = s_fire && (count_reg < FULL);
        end else if (state_reg == ST_PLACE) begin
            wr_en   = out_free;
            wr_addr = min_idx_reg;
            wr_data = pos_val_reg;
        end
    end

    // next-state logic
    always_comb begin
        state_next    = state_reg;
        count_next    = count_reg;
        ovf_next      = ovf_reg;
        pos_next      = pos_reg;
        rd_idx_next   = rd_idx_reg;
        rd_valid_next = rd_en;
        rd_addr_next  = rd_idx_reg[AW-1:0];
        min_next      = min_reg;
        min_idx_next  = min_idx_reg;
        pos_val_next  = pos_val_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;
        m_tlast_next  = m_tlast_reg;
        m_tuser_next  = m_tuser_reg;

        case (state_reg)
            ST_LOAD: begin
                if (s_fire) begin
                    if (count_reg < FULL) begin
                        count_next = count_reg + CW'(1);
                    end else begin
                        ovf_next = 1'b1;
                    end
                    if (s_tlast) begin
                        state_next  = ST_SCAN;
                        pos_next    = '0;
                        rd_idx_next = '0;
                    end
                end
            end
            ST_SCAN: begin
                if (rd_en) begin
                    rd_idx_next = rd_idx_reg + CW'(1);
                end
                if (rd_valid_reg) begin
                    if (first_rd) begin
                        pos_val_next = rd_data;
                    end
                    if (take) begin
                        min_next     = rd_data;
                        min_idx_next = rd_addr_reg;
                    end
                end
                if (last_rd) begin
                    state_next = ST_PLACE;
                end
            end
            ST_PLACE: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = min_reg;
                    m_tlast_next  = last_pos;
                    m_tuser_next  = ovf_reg;
                    if (last_pos) begin
                        state_next = ST_LOAD;
                        count_next = '0;
                        ovf_next   = 1'b0;
                    end else begin
                        state_next  = ST_SCAN;
                        pos_next    = pos_reg + AW'(1);
                        rd_idx_next = CW'(pos_reg) + CW'(1);
                    end
                end
            end
            default: begin
                state_next = ST_LOAD;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_LOAD;
            count_reg    <= '0;
            ovf_reg      <= 1'b0;
            pos_reg      <= '0;
            rd_idx_reg   <= '0;
            rd_valid_reg <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            ovf_reg      <= ovf_next;
            pos_reg      <= pos_next;
            rd_idx_reg   <= rd_idx_next;
            rd_valid_reg <= rd_valid_next;
            m_tvalid_reg <= m_tvalid_next;
        end
        rd_addr_reg <= rd_addr_next;
        min_reg     <= min_next;
        min_idx_reg <= min_idx_next;
        pos_val_reg <= pos_val_next;
        m_tdata_reg <= m_tdata_next;
        m_tlast_reg <= m_tlast_next;
        m_tuser_reg <= m_tuser_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;
    assign m_tuser  = m_tuser_reg;

    // checks
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= FULL)
        else $error("element count beyond store depth");

    a_ovf_full: assert property (@(posedge aclk) disable iff (!aresetn)
        ovf_reg |-> (count_reg == FULL))
        else $error("overflow flag set while store not full");

    a_last_starts_run: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_fire && s_tlast) |=> (state_reg == ST_SCAN))
        else $error("last word did not start a run");

    a_pos_in_set: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_LOAD) |-> (CW'(pos_reg) < count_reg))
        else $error("pass position outside the loaded set");

    a_no_write_in_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SCAN) |-> !wr_en)
        else $error("store written while a scan reads it");

endmodule

/* bench/ascending_integer_sorter_top_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ascending_integer_sorter_top_tb
// Self-checking bench for the ascending integer sorter. Sets of signed words
// go in on s_; each set is sorted by a behavioural copy of the sorter and
// every word that comes out on m_ is checked against the oldest expectation.
// A short table of directed sets comes first, then random sets of mostly
// small sizes, with one set that fills the store and then overflows it.
// Both channels idle at random.
// ----------------------------------------------------------------------------
module ascending_integer_sorter_top_tb;
    import ais_pkg::*;

    localparam int DEPTH      = DEPTH_DEF;
    localparam int HALF_CYCLE = 5;

    localparam value_t VAL_MAX = {1'b0, {(VALUE_W-1){1'b1}}};
    localparam value_t VAL_MIN = {1'b1, {(VALUE_W-1){1'b0}}};

    // one output word as the sorter should produce it
    typedef struct packed {
        value_t value;
        logic   last;
        logic   ovf;
    } sort_word_t;

    // directed table row; exp_* only used when typed is set
    typedef struct packed {
        value_t value;
        logic   last;
        logic   typed;
        value_t exp_value;
        logic   exp_last;
        logic   exp_ovf;
    } dir_row_t;

    localparam int DIR_ROWS = 24;

    logic               aclk;
    logic               aresetn;
    logic [VALUE_W-1:0] s_tdata;
    logic               s_tlast;
    logic               s_tvalid;
    logic               s_tready;
    logic [VALUE_W-1:0] m_tdata;
    logic               m_tlast;
    logic               m_tuser;
    logic               m_tvalid;
    logic               m_tready;

    // sorter state as the bench sees it
    value_t held_set [DEPTH];
    int     held_count = 0;
    logic   dropped    = 1'b0;

    sort_word_t pending_sorted [$];
    int         mismatch_count = 0;
    bit         sink_calm      = 1'b0;

    dir_row_t dir_tab [DIR_ROWS] = '{
        // single-word sets: the result is the word itself
        '{VAL_MAX,         1'b1, 1'b1, VAL_MAX,         1'b1, 1'b0},
        '{VAL_MIN,         1'b1, 1'b1, VAL_MIN,         1'b1, 1'b0},
        '{value_t'(0),     1'b1, 1'b1, value_t'(0),     1'b1, 1'b0},
        '{value_t'(-1),    1'b1, 1'b1, value_t'(-1),    1'b1, 1'b0},
        // mixed signs, extremes twice, alternating bit patterns
        '{VAL_MAX,               1'b0, 1'b0, value_t'(0), 1'b0, 1'b0},
        '{VAL_MIN,               1'b0, 1'b0, value_t'(0), 1'b0, 1'b0},
        '{value_t'(32'h5555_5555), 1'b0, 1'b0, value_t'(0), 1'b0, 1'b0},
        '{value_t'(-1),          1'b0, 1'b0, value_t'(0), 1'b0, 1'b0},
        '{value_t'(32'hAAAA_AAAA), 1'b0, 1'b0, value_t'(0), 1'b0, 1'b0},
        '{VAL_MIN,               1'b0, 1'b0, value_t'(0), 1'b0, 1'b0},
        '{VAL_MAX,               1'b1, 1'b0, value_t'(0), 1'b0, 1'b0},
        // all equal
        '{value_t'(5),  1'b0, 1'b0, value_t'(0), 1'b0, 1'b0},
        '{value_t'(5),  1'b0, 1'b0, value_t'(0), 1'b0, 1'b0},
        '{value_t'(5),  1'b1, 1'b0, value_t'(0), 1'b0, 1'b0},
        // already ascending
        '{value_t'(-3), 1'b0, 1'b0, value_t'(0), 1'b0, 1'b0},
        '{value_t'(-2), 1'b0, 1'b0, value_t'(0), 1'b0, 1'b0},
        '{value_t'(-1), 1'b0, 1'b0, value_t'(0), 1'b0, 1'b0},
        '{value_t'(0),  1'b0, 1'b0, value_t'(0), 1'b0, 1'b0},
        '{value_t'(1),  1'b0, 1'b0, value_t'(0), 1'b0, 1'b0},
        '{value_t'(2),  1'b1, 1'b0, value_t'(0), 1'b0, 1'b0},
        // descending
        '{value_t'(3),  1'b0, 1'b0, value_t'(0), 1'b0, 1'b0},
        '{value_t'(1),  1'b0, 1'b0, value_t'(0), 1'b0, 1'b0},
        '{value_t'(-1), 1'b0, 1'b0, value_t'(0), 1'b0, 1'b0},
        '{value_t'(-3), 1'b1, 1'b0, value_t'(0), 1'b0, 1'b0}
    };

    ascending_integer_sorter_top #(
        .DEPTH    (DEPTH)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready)
    );

    // clock
    initial begin
        aclk = 1'b0;
        forever #HALF_CYCLE aclk = ~aclk;
    end

    // run limit
    initial begin
        #5_000_000;
        $display("ascending_integer_sorter_top test failed");
        $finish;
    end

    // idle length: mostly none, often short, now and then long
    function automatic int gap_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 30);
    endfunction

    // element values biased towards extremes and small values for duplicates
    function automatic value_t random_value();
        case ($urandom_range(0, 9))
            0:       return VAL_MIN;
            1:       return VAL_MAX;
            2, 3, 4: return value_t'($signed($urandom_range(0, 8)) - 4);
            default: return value_t'($urandom);
        endcase
    endfunction

    // store a word; on the last of a set return the set in ascending order
    function automatic void collect_and_sort(input value_t v, input logic last,
                                             output sort_word_t run [$]);
        value_t t;
        int     n;
        run = {};
        if (held_count < DEPTH) begin
            held_set[held_count] = v;
            held_count++;
        end else begin
            dropped = 1'b1;
        end
        if (!last)
            return;
        n = held_count;
        for (int a = 0; a + 1 < n; a++) begin
            for (int b = a + 1; b < n; b++) begin
                if (held_set[a] > held_set[b]) begin
                    t           = held_set[a];
                    held_set[a] = held_set[b];
                    held_set[b] = t;
                end
            end
        end
        for (int k = 0; k < n; k++)
            run.push_back(sort_word_t'{held_set[k], (k == n - 1), dropped});
        held_count = 0;
        dropped    = 1'b0;
    endfunction

    // offer one word on s_; entered and left at a falling edge
    task automatic send_word(input value_t v, input logic last, input bit quiet);
        int gap;
        gap = quiet ? 0 : gap_length();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tdata  <= v;
        s_tlast  <= last;
        s_tvalid <= 1'b1;
        do
            @(posedge aclk);
        while (!s_tready);
        @(negedge aclk);
    endtask

    // one random set of n words; results can only follow the last handshake
    task automatic send_set(input int n, input bit quiet);
        sort_word_t run [$];
        value_t     v;
        for (int i = 0; i < n; i++) begin
            v = random_value();
            send_word(v, (i == n - 1), quiet);
            collect_and_sort(v, (i == n - 1), run);
            foreach (run[k])
                pending_sorted.push_back(run[k]);
        end
    endtask

    // result side back-pressure
    initial begin : drain
        int stall;
        stall    = 0;
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (stall > 0) begin
                m_tready <= 1'b0;
                stall--;
            end else begin
                m_tready <= 1'b1;
                if (!sink_calm && $urandom_range(0, 2) == 0)
                    stall = gap_length();
            end
        end
    end

    // compare every accepted result word with the oldest expectation
    always @(posedge aclk) begin : check_sorted
        sort_word_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_sorted.size() == 0) begin
                $error("unexpected word: sorted_value %0d is_last %0b overflowed %0b",
                       $signed(m_tdata), m_tlast, m_tuser);
                mismatch_count++;
            end else begin
                want = pending_sorted.pop_front();
                if (m_tdata !== want.value) begin
                    $error("sorted_value: expected %0d, got %0d",
                           want.value, $signed(m_tdata));
                    mismatch_count++;
                end
                if (m_tlast !== want.last) begin
                    $error("is_last: expected %0b, got %0b", want.last, m_tlast);
                    mismatch_count++;
                end
                if (m_tuser !== want.ovf) begin
                    $error("overflowed: expected %0b, got %0b", want.ovf, m_tuser);
                    mismatch_count++;
                end
            end
        end
    end

    // stimulus
    initial begin
        sort_word_t run [$];
        int         set_idx;
        int         small_items;
        int         n;
        int         over_set;
        bit         quiet;

        aresetn  = 1'b0;
        s_tdata  = '0;
        s_tlast  = 1'b0;
        s_tvalid = 1'b0;
        repeat (5) @(negedge aclk);
        aresetn <= 1'b1;

        // directed sets
        foreach (dir_tab[r]) begin
            send_word(dir_tab[r].value, dir_tab[r].last, 1'b0);
            collect_and_sort(dir_tab[r].value, dir_tab[r].last, run);
            if (dir_tab[r].typed)
                pending_sorted.push_back(sort_word_t'{dir_tab[r].exp_value,
                                                      dir_tab[r].exp_last,
                                                      dir_tab[r].exp_ovf});
            else
                foreach (run[k])
                    pending_sorted.push_back(run[k]);
        end

        // random sets; one fills the store and then overflows it
        over_set    = $urandom_range(2, 5);
        set_idx     = 0;
        small_items = 0;
        while (small_items < 40 || set_idx <= over_set) begin
            quiet     = ($urandom_range(0, 4) == 0);
            sink_calm <= ($urandom_range(0, 4) == 0);
            if (set_idx == over_set) begin
                n = DEPTH + 1;
            end else begin
                n = ($urandom_range(0, 4) == 0) ? $urandom_range(9, 20) : $urandom_range(1, 8);
                small_items += n;
            end
            send_set(n, quiet);
            set_idx++;
        end
        s_tvalid <= 1'b0;

        // drain, then allow for any stray words
        while (pending_sorted.size() != 0)
            @(posedge aclk);
        repeat (4 * DEPTH) @(posedge aclk);

        if (mismatch_count == 0 && pending_sorted.size() == 0)
            $display("ascending_integer_sorter_top test passed");
        else
            $display("ascending_integer_sorter_top test failed");
        $finish;
    end

endmodule

/* sim.f */
rtl/core/ais_pkg.sv
rtl/core/ais_ram.sv
rtl/core/ascending_integer_sorter_top.sv
bench/ascending_integer_sorter_top_tb.sv
